// ----- rtl/valu_pkg.sv -----
// ----------------------------------------------------------------------------
// VLIW ALU package
// Shared width constants, opcode encoding and the pipeline stage record.
// ----------------------------------------------------------------------------
package valu_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int W          = DATA_WIDTH;
  // Quotient bits resolved in each divider stage.
  localparam int BPS        = 2;
  localparam int DIV_STAGES = W / BPS;
  // Input register, operate stage, divider stages, output register.
  localparam int LATENCY    = DIV_STAGES + 3;

  typedef enum logic [4:0] {
    OP_IDLE     = 5'd0,
    OP_ADD      = 5'd1,
    OP_SUB      = 5'd2,
    OP_SHL      = 5'd3,
    OP_SHR      = 5'd4,
    OP_SHRU     = 5'd5,
    OP_AND      = 5'd6,
    OP_OR       = 5'd7,
    OP_XOR      = 5'd8,
    OP_ADDCG    = 5'd9,
    OP_SUBCG    = 5'd10,
    OP_CMPEQ    = 5'd11,
    OP_CMPGE    = 5'd12,
    OP_CMPGEU   = 5'd13,
    OP_CMPGT    = 5'd14,
    OP_CMPGTU   = 5'd15,
    OP_CMPLE    = 5'd16,
    OP_CMPLEU   = 5'd17,
    OP_CMPLT    = 5'd18,
    OP_CMPNE    = 5'd19,
    OP_ORL      = 5'd20,
    OP_SLCT     = 5'd21,
    OP_SLCTF    = 5'd22,
    OP_MULL     = 5'd23,
    OP_MULL64H  = 5'd24,
    OP_MULL64HU = 5'd25,
    OP_DIVQ     = 5'd26,
    OP_DIVRU    = 5'd27
  } cmd_t;

  // One item as it moves down the divider stages with its side data.
  typedef struct packed {
    logic             vld;
    cmd_t             cmd;
    logic [W-1:0]     a;
    logic [W-1:0]     s2;
    logic [W-1:0]     res;
    logic             pred;
    logic [2*W-1:0]   prod;
    logic             neg;
    logic             dz;
    logic [W-1:0]     n;
    logic [W-1:0]     rem;
    logic [W-1:0]     d;
  } stage_t;

endpackage

// ----- rtl/vliw_integer_alu.sv -----
// ----------------------------------------------------------------------------
// VLIW integer ALU
// One issue slot of integer operations, fully pipelined, one result per item.
// ----------------------------------------------------------------------------
// The block takes one operation in every clock cycle: busy is always low, so
// a transfer happens at every edge where start is high. Every operation,
// whatever its kind, passes through the same registers: one input register,
// one operate stage holding the adder, compare and 32x32 multiplier, sixteen
// divider stages that each resolve two quotient bits, and the output
// register. Results come out in issue order with done high for exactly one
// cycle; the receiver cannot stall, so it must take each result in the cycle
// it appears.
module vliw_integer_alu
  import valu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  cmd,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  input  logic [31:0] immediate,
  input  logic        use_immediate,
  input  logic        cond_in,
  output logic        done,
  output logic [31:0] result,
  output logic        predicate
);

  // The pipeline never holds off new work.
  assign busy = 1'b0;

  // Input register. The second operand is chosen here; carry operations
  // always read the second register.
  logic         in_vld;
  cmd_t         in_cmd;
  logic [W-1:0] in_a;
  logic [W-1:0] in_s2;
  logic         in_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start && !busy;
    end
    in_cmd <= cmd_t'(cmd);
    in_a   <= operand_a[W-1:0];
    in_c   <= cond_in;
    if (use_immediate && cmd != OP_ADDCG && cmd != OP_SUBCG) begin
      in_s2 <= immediate[W-1:0];
    end else begin
      in_s2 <= operand_b[W-1:0];
    end
  end

  stage_t pipe      [DIV_STAGES+1];
  stage_t pipe_next [DIV_STAGES+1];

  // Operate stage: the simple operations finish here, the product is
  // formed, and the divider operands are made positive for the signed case.
  logic [W:0]   carry_sum;
  logic [W-1:0] shr_res;

  always_comb begin
    carry_sum = '0;
    shr_res   = W'($signed(in_a) >>> in_s2[4:0]);
    pipe_next[0]      = '0;
    pipe_next[0].vld  = in_vld;
    pipe_next[0].cmd  = in_cmd;
    pipe_next[0].a    = in_a;
    pipe_next[0].s2   = in_s2;
    pipe_next[0].prod = in_a * in_s2;
    case (in_cmd)
      OP_ADD:  pipe_next[0].res = in_a + in_s2;
      OP_SUB:  pipe_next[0].res = in_s2 - in_a;
      OP_SHL: begin
        if ({1'b0, in_s2[4:0]} >= 6'(W)) begin
          pipe_next[0].res = '0;
        end else begin
          pipe_next[0].res = in_a << in_s2[4:0];
        end
      end
      OP_SHR: begin
        if ({1'b0, in_s2[4:0]} >= 6'(W)) begin
          pipe_next[0].res = {W{in_a[W-1]}};
        end else begin
          pipe_next[0].res = shr_res;
        end
      end
      OP_SHRU: begin
        if ({1'b0, in_s2[4:0]} >= 6'(W)) begin
          pipe_next[0].res = '0;
        end else begin
          pipe_next[0].res = in_a >> in_s2[4:0];
        end
      end
      OP_AND:  pipe_next[0].res = in_a & in_s2;
      OP_OR:   pipe_next[0].res = in_a | in_s2;
      OP_XOR:  pipe_next[0].res = in_a ^ in_s2;
      OP_ADDCG: begin
        carry_sum = {1'b0, in_a} + {1'b0, in_s2} + {{W{1'b0}}, in_c};
        pipe_next[0].res  = carry_sum[W-1:0];
        pipe_next[0].pred = (in_a[W-1] == in_s2[W-1]) &&
                            (carry_sum[W-1] != in_a[W-1]);
      end
      OP_SUBCG: begin
        carry_sum = {1'b0, in_a} + {1'b0, ~in_s2} + {{W{1'b0}}, in_c};
        pipe_next[0].res  = carry_sum[W-1:0];
        pipe_next[0].pred = (in_a[W-1] != in_s2[W-1]) &&
                            (carry_sum[W-1] != in_a[W-1]);
      end
      OP_CMPEQ:  pipe_next[0].pred = in_a == in_s2;
      OP_CMPGE:  pipe_next[0].pred = $signed(in_a) >= $signed(in_s2);
      OP_CMPGEU: pipe_next[0].pred = in_a >= in_s2;
      OP_CMPGT:  pipe_next[0].pred = $signed(in_a) > $signed(in_s2);
      OP_CMPGTU: pipe_next[0].pred = in_a > in_s2;
      OP_CMPLE:  pipe_next[0].pred = $signed(in_a) <= $signed(in_s2);
      OP_CMPLEU: pipe_next[0].pred = in_a <= in_s2;
      OP_CMPLT:  pipe_next[0].pred = $signed(in_a) < $signed(in_s2);
      OP_CMPNE:  pipe_next[0].pred = in_a != in_s2;
      OP_ORL:    pipe_next[0].pred = (in_a != '0) || (in_s2 != '0);
      OP_SLCT:   pipe_next[0].res  = in_c ? in_a : in_s2;
      OP_SLCTF:  pipe_next[0].res  = in_c ? in_s2 : in_a;
      OP_DIVQ: begin
        pipe_next[0].n   = in_a[W-1] ? -in_a : in_a;
        pipe_next[0].d   = in_s2[W-1] ? -in_s2 : in_s2;
        pipe_next[0].neg = in_a[W-1] ^ in_s2[W-1];
      end
      OP_DIVRU: begin
        pipe_next[0].n = in_a;
        pipe_next[0].d = in_s2;
      end
      default: pipe_next[0].res = '0;
    endcase
    // Compares report their outcome in the word as well.
    if (in_cmd >= OP_CMPEQ && in_cmd <= OP_ORL) begin
      pipe_next[0].res = {{(W-1){1'b0}}, pipe_next[0].pred};
    end
    pipe_next[0].dz = in_s2 == '0;
  end

  // Restoring divider: the dividend shifts out of n while quotient bits
  // shift in behind it; rem stays below the divisor.
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    stage_t     st;
    logic [W:0] trial;

    always_comb begin
      st    = pipe[k-1];
      trial = '0;
      for (int j = 0; j < BPS; j++) begin
        trial = {st.rem, st.n[W-1]};
        st.n  = {st.n[W-2:0], 1'b0};
        if (trial >= {1'b0, st.d}) begin
          trial   = trial - {1'b0, st.d};
          st.n[0] = 1'b1;
        end
        st.rem = trial[W-1:0];
      end
      pipe_next[k] = st;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= DIV_STAGES; k++) begin
      if (rst) begin
        pipe[k] <= '0;
      end else begin
        pipe[k] <= pipe_next[k];
      end
    end
  end

  // Output stage: the signed high product is corrected from the unsigned
  // one, and the quotient takes its sign.
  stage_t       fin;
  logic [W-1:0] result_next;
  cmd_t         out_cmd;

  assign fin = pipe[DIV_STAGES];

  always_comb begin
    case (fin.cmd)
      OP_MULL:     result_next = fin.prod[W-1:0];
      OP_MULL64HU: result_next = fin.prod[2*W-1:W];
      OP_MULL64H:  result_next = fin.prod[2*W-1:W]
                               - (fin.a[W-1]  ? fin.s2 : '0)
                               - (fin.s2[W-1] ? fin.a  : '0);
      OP_DIVQ:     result_next = fin.dz ? '0 : (fin.neg ? -fin.n : fin.n);
      OP_DIVRU:    result_next = fin.dz ? '0 : fin.rem;
      default:     result_next = fin.res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.vld;
    end
    result    <= 32'(result_next);
    predicate <= fin.pred;
    out_cmd   <= fin.cmd;
  end

  // Every result comes from a matching earlier transfer through the pipeline.
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && !rst, LATENCY))
    else $error("result without matching transfer");

  // Only compares, orl and the carry operations raise the predicate.
  a_pred_ops: assert property (@(posedge clk) disable iff (rst)
    (done && predicate) |->
      ((out_cmd >= OP_CMPEQ && out_cmd <= OP_ORL) ||
       out_cmd == OP_ADDCG || out_cmd == OP_SUBCG))
    else $error("predicate raised by wrong operation");

  // Compare results are a single bit that matches the predicate.
  a_cmp_word: assert property (@(posedge clk) disable iff (rst)
    (done && out_cmd >= OP_CMPEQ && out_cmd <= OP_ORL) |->
      (result == {31'd0, predicate}))
    else $error("compare result word mismatch");

endmodule

// ----- sim/alu_checker.sv -----
// ----------------------------------------------------------------------------
// VLIW ALU result checker
// Watches the issue and result channels, computes each expected result and
// compares it field by field with what the block returns, in issue order.
// ----------------------------------------------------------------------------
module alu_checker
  import valu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [4:0]  cmd,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  input  logic [31:0] immediate,
  input  logic        use_immediate,
  input  logic        cond_in,
  input  logic        done,
  input  logic [31:0] result,
  input  logic        predicate,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic        flag;
  } alu_out_t;

  alu_out_t expected_q[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Computes the word and flag that one operation must produce.
  function automatic alu_out_t compute_alu(input logic [4:0] op, input logic [31:0] a,
                                           input logic [31:0] b, input logic [31:0] imm,
                                           input logic sel, input logic c);
    logic [31:0] s2;
    logic [31:0] r;
    logic        p;
    logic [63:0] prod;
    alu_out_t    o;
    s2 = sel ? imm : b;
    r  = '0;
    p  = 1'b0;
    case (op)
      OP_ADD:   r = a + s2;
      OP_SUB:   r = s2 - a;
      OP_SHL:   r = a << s2[4:0];
      OP_SHR:   r = $signed(a) >>> s2[4:0];
      OP_SHRU:  r = a >> s2[4:0];
      OP_AND:   r = a & s2;
      OP_OR:    r = a | s2;
      OP_XOR:   r = a ^ s2;
      OP_ADDCG: begin
        r = a + b + {31'b0, c};
        p = (a[31] == b[31]) && (r[31] != a[31]);
      end
      OP_SUBCG: begin
        r = a + ~b + {31'b0, c};
        p = (a[31] != b[31]) && (r[31] != a[31]);
      end
      OP_CMPEQ:  p = a == s2;
      OP_CMPGE:  p = $signed(a) >= $signed(s2);
      OP_CMPGEU: p = a >= s2;
      OP_CMPGT:  p = $signed(a) > $signed(s2);
      OP_CMPGTU: p = a > s2;
      OP_CMPLE:  p = $signed(a) <= $signed(s2);
      OP_CMPLEU: p = a <= s2;
      OP_CMPLT:  p = $signed(a) < $signed(s2);
      OP_CMPNE:  p = a != s2;
      OP_ORL:    p = (a != 0) || (s2 != 0);
      OP_SLCT:   r = c ? a : s2;
      OP_SLCTF:  r = c ? s2 : a;
      OP_MULL:   r = a * s2;
      OP_MULL64H: begin
        prod = $signed({{32{a[31]}}, a}) * $signed({{32{s2[31]}}, s2});
        r = prod[63:32];
      end
      OP_MULL64HU: begin
        prod = {32'b0, a} * {32'b0, s2};
        r = prod[63:32];
      end
      OP_DIVQ: begin
        // The most negative value over minus one wraps back to itself.
        if (s2 == 0) r = '0;
        else if (a == 32'h8000_0000 && s2 == 32'hFFFF_FFFF) r = a;
        else r = $signed(a) / $signed(s2);
      end
      OP_DIVRU:  r = (s2 == 0) ? '0 : a % s2;
      default:   r = '0;
    endcase
    if (op >= OP_CMPEQ && op <= OP_ORL) r = {31'b0, p};
    o.word = r;
    o.flag = p;
    return o;
  endfunction

  always @(posedge clk) begin
    alu_out_t want;
    if (rst) begin
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", result, '0);
        end else begin
          want = expected_q.pop_front();
          if (result !== want.word) report_mismatch("result", result, want.word);
          if (predicate !== want.flag)
            report_mismatch("predicate", {31'b0, predicate}, {31'b0, want.flag});
        end
      end
      if (start && !busy)
        expected_q.push_back(compute_alu(cmd, operand_a, operand_b, immediate,
                                         use_immediate, cond_in));
    end
    pending = expected_q.size();
  end

endmodule

// ----- sim/tb_vliw_integer_alu.sv -----
// ----------------------------------------------------------------------------
// VLIW ALU testbench
// Issues directed corner operations and then random ones under varying issue
// gaps; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_vliw_integer_alu;
  import valu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [4:0]  cmd;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  logic [31:0] immediate;
  logic        use_immediate;
  logic        cond_in;
  logic        done;
  logic [31:0] result;
  logic        predicate;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;

  // The sender idles in this many cycles out of a hundred.
  int          gap_percent;

  localparam int CYCLE_LIMIT = 200000;

  vliw_integer_alu uut (
    .clk, .rst, .start, .busy, .cmd, .operand_a, .operand_b, .immediate,
    .use_immediate, .cond_in, .done, .result, .predicate
  );

  alu_checker u_checker (
    .clk, .rst, .start, .busy, .cmd, .operand_a, .operand_b, .immediate,
    .use_immediate, .cond_in, .done, .result, .predicate, .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The watchdog ends a run that hangs, counting every clock from time zero.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Picks an operand with a bias toward zero, small values and the edges of the
  // signed range, where the carries, overflows and compares change their outcome.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(0, 40);
      5: return -$urandom_range(0, 40);
      default: return $urandom();
    endcase
  endfunction

  // Offers one operation and holds it until the transfer at a rising edge.
  // Random idle cycles are inserted before the offer, never between two
  // assignments to start in the same time step.
  task automatic issue(input logic [4:0] op, input logic [31:0] a, input logic [31:0] b,
                       input logic [31:0] imm, input logic sel, input logic c);
    while ($urandom_range(0, 99) < gap_percent) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    cmd           <= op;
    operand_a     <= a;
    operand_b     <= b;
    immediate     <= imm;
    use_immediate <= sel;
    cond_in       <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic issue_random();
    issue(5'($urandom_range(0, 31)), pick_operand(), pick_operand(), pick_operand(),
          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    gap_percent   = 0;
    rst           = 1'b1;
    start         = 1'b0;
    cmd           = OP_IDLE;
    operand_a     = '0;
    operand_b     = '0;
    immediate     = '0;
    use_immediate = 1'b0;
    cond_in       = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners: the overflow of each carry operation, shifts by zero
    // and by the largest amount, the wrapping quotient, division by zero,
    // the high multiplies at the extremes, selects both ways, and an opcode
    // beyond the last defined one.
    issue(OP_IDLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    issue(OP_ADD, 32'h7FFF_FFFF, 32'h1, 32'h0, 1'b0, 1'b0);
    issue(OP_SUB, 32'h1, 32'h0, 32'h8000_0000, 1'b1, 1'b0);
    issue(OP_SHL, 32'hFFFF_FFFF, 32'h0, 32'd31, 1'b1, 1'b0);
    issue(OP_SHR, 32'h8000_0000, 32'd31, 32'h0, 1'b0, 1'b0);
    issue(OP_SHRU, 32'h8000_0000, 32'hFFFF_FFE0, 32'h0, 1'b0, 1'b0);
    issue(OP_ADDCG, 32'h7FFF_FFFF, 32'h0, 32'h5, 1'b1, 1'b1);
    issue(OP_ADDCG, 32'h8000_0000, 32'h8000_0000, 32'h0, 1'b0, 1'b0);
    issue(OP_SUBCG, 32'h8000_0000, 32'h1, 32'h0, 1'b1, 1'b1);
    issue(OP_SUBCG, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b1);
    issue(OP_CMPGE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0);
    issue(OP_CMPGTU, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0);
    issue(OP_ORL, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0);
    issue(OP_SLCT, 32'h1234_5678, 32'h0, 32'h9ABC_DEF0, 1'b1, 1'b1);
    issue(OP_SLCTF, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0, 1'b0, 1'b1);
    issue(OP_MULL64H, 32'h8000_0000, 32'h8000_0000, 32'h0, 1'b0, 1'b0);
    issue(OP_MULL64HU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
    issue(OP_DIVQ, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
    issue(OP_DIVQ, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, 1'b0);
    issue(OP_DIVQ, 32'hFFFF_FFF9, 32'h2, 32'h0, 1'b0, 1'b0);
    issue(OP_DIVRU, 32'hFFFF_FFFF, 32'h0, 32'h7, 1'b1, 1'b0);
    issue(OP_DIVRU, 32'hFFFF_FFFF, 32'h10, 32'h0, 1'b0, 1'b0);
    issue(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);

    // Random operations in three phases of issue pressure.
    gap_percent = 7;
    repeat (580) issue_random();
    gap_percent = 84;
    repeat (580) issue_random();
    gap_percent = 0;
    repeat (580) issue_random();
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/valu_pkg.sv
rtl/vliw_integer_alu.sv
sim/alu_checker.sv
sim/tb_vliw_integer_alu.sv
